// ===== rtl/sfd_pkg.sv =====
// Shared constants, types and helper functions for the stereo feedback delay.
package sfd_pkg;

    // Default sizing of the delay stores and samples.
    localparam int DEF_BUFFER_DEPTH = 131072;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Q15 arithmetic.
    localparam int Q15_SHIFT = 15;
    localparam int GAIN_W    = 17;
    localparam logic [GAIN_W-1:0] Q15_ONE = GAIN_W'(32768);

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 18;
    localparam int DELAY_W    = 18;
    localparam int GAIN_IN_W  = 16;

    localparam logic [DELAY_W-1:0]   DELAY_RESET = DELAY_W'(44100);
    localparam logic [GAIN_IN_W-1:0] GAIN_RESET  = GAIN_IN_W'(16384);

    // Result buffer between the datapath and the output channel.
    localparam int OUT_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYPASS    = CFG_IDX_W'(0),
        CFG_DELAY     = CFG_IDX_W'(1),
        CFG_FB_GAIN   = CFG_IDX_W'(2),
        CFG_WET_GAIN  = CFG_IDX_W'(3)
    } cfg_reg_t;

    // Per-cycle controls from the sequencing logic to each channel datapath.
    typedef struct packed {
        logic accept;   // load a new input sample
        logic rd_en;    // read the delay store (first stage)
        logic fwd;      // take the delayed sample from the pending write (second stage)
        logic filled;   // the addressed entry has been written since reset (second stage)
        logic byp;      // the frame in the third stage is passed through
        logic wr_en;    // write the delay store (fourth stage)
    } sfd_ctrl_t;

    // Gains above unity are held at unity.
    function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_IN_W-1:0] g);
        logic [GAIN_W-1:0] gx;
        gx = GAIN_W'(g);
        return (gx > Q15_ONE) ? Q15_ONE : gx;
    endfunction

    // A zero delay acts as one sample; a delay beyond the store acts as the whole store.
    function automatic int unsigned clamp_delay(input logic [DELAY_W-1:0] v,
                                                input int unsigned depth);
        int unsigned vx;
        vx = 32'(v);
        if (vx == 0)
            return 1;
        if (vx > depth)
            return depth;
        return vx;
    endfunction

endpackage

// ===== rtl/sfd_chan.sv =====
// One channel of the delay: sample store, forwarding, Q15 mix and feedback arithmetic.
module sfd_chan #(
    parameter int BUFFER_DEPTH = sfd_pkg::DEF_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = sfd_pkg::DEF_SAMPLE_WIDTH,
    parameter int AW           = $clog2(BUFFER_DEPTH)
) (
    input  logic                                clk,
    input  sfd_pkg::sfd_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]      x_in,
    input  logic        [AW-1:0]                rd_addr,
    input  logic        [AW-1:0]                wr_addr,
    input  logic        [sfd_pkg::GAIN_W-1:0]   dry_gain,
    input  logic        [sfd_pkg::GAIN_W-1:0]   wet_gain,
    input  logic        [sfd_pkg::GAIN_W-1:0]   fb_gain,
    output logic signed [SAMPLE_WIDTH-1:0]      y
);

    localparam int PW = SAMPLE_WIDTH + sfd_pkg::GAIN_W + 1;

    logic signed [SAMPLE_WIDTH-1:0] mem [BUFFER_DEPTH];

    logic signed [SAMPLE_WIDTH-1:0] x1_reg;
    logic signed [SAMPLE_WIDTH-1:0] x2_reg;
    logic signed [SAMPLE_WIDTH-1:0] x3_reg;
    logic signed [SAMPLE_WIDTH-1:0] rdata_reg;
    logic signed [SAMPLE_WIDTH-1:0] wdata_reg;
    logic signed [SAMPLE_WIDTH-1:0] wdata_next;
    logic signed [PW-1:0]           pdry_reg;
    logic signed [PW-1:0]           pwet_reg;
    logic signed [PW-1:0]           pfb_reg;

    logic signed [SAMPLE_WIDTH-1:0] delayed;
    logic signed [PW:0]             mix_sum;
    logic signed [PW:0]             mix_shift;
    logic signed [PW-1:0]           fb_shift;
    logic signed [PW:0]             fb_sum;

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [PW:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[PW:SAMPLE_WIDTH-1];
        all_zero = ~|v[PW:SAMPLE_WIDTH-1];
        if (all_one || all_zero)
            return v[SAMPLE_WIDTH-1:0];
        return v[PW] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    endfunction

    // Single-port store: the sequencer never asks for a read and a write in one cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wdata_reg;
        end
        else if (ctrl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Entries never written since reset read as silence.
    always_comb
    begin
        if (ctrl.fwd)
            delayed = wdata_reg;
        else if (ctrl.filled)
            delayed = rdata_reg;
        else
            delayed = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            x1_reg <= x_in;
        end
        x2_reg    <= x1_reg;
        x3_reg    <= x2_reg;
        pdry_reg  <= $signed({1'b0, dry_gain}) * x2_reg;
        pwet_reg  <= $signed({1'b0, wet_gain}) * delayed;
        pfb_reg   <= $signed({1'b0, fb_gain}) * delayed;
        wdata_reg <= wdata_next;
    end

    always_comb
    begin
        mix_sum    = (PW+1)'(pdry_reg) + (PW+1)'(pwet_reg);
        mix_shift  = mix_sum >>> sfd_pkg::Q15_SHIFT;
        fb_shift   = pfb_reg >>> sfd_pkg::Q15_SHIFT;
        fb_sum     = (PW+1)'(x3_reg) + (PW+1)'(fb_shift);
        wdata_next = sat_sample(fb_sum);
        y          = ctrl.byp ? x3_reg : sat_sample(mix_shift);
    end

endmodule

// ===== rtl/stereo_feedback_delay_core.sv =====
// Stereo feedback delay: per-channel delay store, Q15 dry/wet mix and saturating feedback.
// The frame rate is set by the single port of each channel store, which takes one read
// and one write per frame: a new frame waits while one is in stage one, while a writing
// frame is in stage three, or while the output queue has no free slot.
// Reset: registers take their reset values at once; the stores are not swept, a fill
// marker makes entries not yet written read as zero, so frames are taken straight away.
module stereo_feedback_delay_core #(
    parameter int BUFFER_DEPTH = sfd_pkg::DEF_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = sfd_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]       left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]       right_in,
    input  logic                                 block_end_in,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]       left_out,
    output logic signed [SAMPLE_WIDTH-1:0]       right_out,
    output logic                                 block_end_out,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Store address width, and a width that can also hold the full depth.
    localparam int AW     = $clog2(BUFFER_DEPTH);
    localparam int LW     = $clog2(BUFFER_DEPTH + 1);
    localparam int QPW    = $clog2(sfd_pkg::OUT_DEPTH);
    localparam int CNTW   = $clog2(sfd_pkg::OUT_DEPTH + 1);
    localparam logic [LW-1:0]   DEPTH_L    = LW'(BUFFER_DEPTH);
    localparam logic [AW-1:0]   LAST_POS   = AW'(BUFFER_DEPTH - 1);
    localparam logic [CNTW-1:0] OUT_FULL   = CNTW'(sfd_pkg::OUT_DEPTH);
    localparam logic [LW-1:0]   DELAY_INIT =
        LW'(sfd_pkg::clamp_delay(sfd_pkg::DELAY_RESET, BUFFER_DEPTH));

    // ------------------------------------------------------------------
    // Configuration registers. Gains and delay are held already clamped,
    // and the dry gain is kept alongside the wet gain, so that the frame
    // path sees plain operands.
    // ------------------------------------------------------------------
    logic                       bypass_reg;
    logic [LW-1:0]              delay_reg;
    logic [sfd_pkg::GAIN_W-1:0] fb_gain_reg;
    logic [sfd_pkg::GAIN_W-1:0] wet_gain_reg;
    logic [sfd_pkg::GAIN_W-1:0] dry_gain_reg;
    logic [sfd_pkg::GAIN_W-1:0] wet_sat;
    logic                       cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign wet_sat   = sfd_pkg::sat_gain(cfg_data[sfd_pkg::GAIN_IN_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg   <= 1'b0;
            delay_reg    <= DELAY_INIT;
            fb_gain_reg  <= sfd_pkg::sat_gain(sfd_pkg::GAIN_RESET);
            wet_gain_reg <= sfd_pkg::sat_gain(sfd_pkg::GAIN_RESET);
            dry_gain_reg <= sfd_pkg::Q15_ONE - sfd_pkg::sat_gain(sfd_pkg::GAIN_RESET);
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                sfd_pkg::CFG_BYPASS:
                begin
                    bypass_reg <= cfg_data[0];
                end
                sfd_pkg::CFG_DELAY:
                begin
                    delay_reg <= LW'(sfd_pkg::clamp_delay(cfg_data[sfd_pkg::DELAY_W-1:0],
                                                          BUFFER_DEPTH));
                end
                sfd_pkg::CFG_FB_GAIN:
                begin
                    fb_gain_reg <= sfd_pkg::sat_gain(cfg_data[sfd_pkg::GAIN_IN_W-1:0]);
                end
                sfd_pkg::CFG_WET_GAIN:
                begin
                    wet_gain_reg <= wet_sat;
                    dry_gain_reg <= sfd_pkg::Q15_ONE - wet_sat;
                end
                default:
                begin
                    // Writes to unassigned indices are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame sequencing. A frame walks through four fixed stages with no
    // stall inside: stage one reads the store, stage two multiplies,
    // stage three sums, saturates and pushes the result beat into the
    // output queue, and stage four writes the store. Back-pressure is
    // handled by counting frames not yet delivered against the queue
    // depth, so a frame is only taken when its result has a slot.
    // ------------------------------------------------------------------
    logic [AW-1:0]   wr_pos_reg;
    logic            wrapped_reg;
    logic [CNTW-1:0] pend_reg;
    logic [CNTW-1:0] pend_next;

    logic            s1_vld_reg;
    logic            s1_byp_reg;
    logic            s1_filled_reg;
    logic            s1_mark_reg;
    logic [AW-1:0]   s1_rd_addr_reg;
    logic [AW-1:0]   s1_wr_addr_reg;

    logic            s2_vld_reg;
    logic            s2_byp_reg;
    logic            s2_filled_reg;
    logic            s2_fwd_reg;
    logic            s2_mark_reg;
    logic [AW-1:0]   s2_wr_addr_reg;

    logic            s3_vld_reg;
    logic            s3_byp_reg;
    logic            s3_mark_reg;
    logic [AW-1:0]   s3_wr_addr_reg;

    logic            s4_wen_reg;
    logic [AW-1:0]   s4_wr_addr_reg;

    logic            in_fire;
    logic            out_fire;
    logic            s3_wen;
    logic            fwd_hit;
    logic [LW-1:0]   wr_ext;
    logic [AW-1:0]   rd_addr_calc;
    logic            filled_calc;

    sfd_pkg::sfd_ctrl_t ctrl;

    // The store port is free in stage one unless the frame now in stage
    // three will be writing in the next cycle.
    assign s3_wen   = s3_vld_reg && !s3_byp_reg;
    assign in_stall = s1_vld_reg || s3_wen || (pend_reg == OUT_FULL);
    assign in_fire  = in_valid && !in_stall;

    // Read position trails the write position by the delay, with wrap. An
    // entry holds real data once the write position has passed it since reset.
    always_comb
    begin
        wr_ext = LW'(wr_pos_reg);
        if (wr_ext >= delay_reg)
            rd_addr_calc = AW'(wr_ext - delay_reg);
        else
            rd_addr_calc = AW'(DEPTH_L - delay_reg + wr_ext);
        filled_calc = wrapped_reg || (wr_ext >= delay_reg);
    end

    // A frame reading the entry its direct predecessor is about to write
    // takes the new value straight from that predecessor's write data.
    assign fwd_hit = s1_vld_reg && !s1_byp_reg && s3_wen && (s3_wr_addr_reg == s1_rd_addr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg    <= '0;
            wrapped_reg   <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s2_fwd_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_wen_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire && !bypass_reg)
            begin
                if (wr_pos_reg == LAST_POS)
                begin
                    wr_pos_reg  <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wr_pos_reg <= wr_pos_reg + AW'(1);
                end
            end
            s1_vld_reg <= in_fire;
            s2_vld_reg <= s1_vld_reg;
            s2_fwd_reg <= fwd_hit;
            s3_vld_reg <= s2_vld_reg;
            s4_wen_reg <= s3_wen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byp_reg     <= bypass_reg;
            s1_filled_reg  <= filled_calc;
            s1_mark_reg    <= block_end_in;
            s1_rd_addr_reg <= rd_addr_calc;
            s1_wr_addr_reg <= wr_pos_reg;
        end
        s2_byp_reg     <= s1_byp_reg;
        s2_filled_reg  <= s1_filled_reg;
        s2_mark_reg    <= s1_mark_reg;
        s2_wr_addr_reg <= s1_wr_addr_reg;
        s3_byp_reg     <= s2_byp_reg;
        s3_mark_reg    <= s2_mark_reg;
        s3_wr_addr_reg <= s2_wr_addr_reg;
        s4_wr_addr_reg <= s3_wr_addr_reg;
    end

    assign ctrl.accept = in_fire;
    assign ctrl.rd_en  = s1_vld_reg && !s1_byp_reg;
    assign ctrl.fwd    = s2_fwd_reg;
    assign ctrl.filled = s2_filled_reg;
    assign ctrl.byp    = s3_byp_reg;
    assign ctrl.wr_en  = s4_wen_reg;

    // ------------------------------------------------------------------
    // Channel datapaths.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] left_y;
    logic signed [SAMPLE_WIDTH-1:0] right_y;

    sfd_chan #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AW           (AW)
    ) u_left (
        .clk      (clk),
        .ctrl     (ctrl),
        .x_in     (left_in),
        .rd_addr  (s1_rd_addr_reg),
        .wr_addr  (s4_wr_addr_reg),
        .dry_gain (dry_gain_reg),
        .wet_gain (wet_gain_reg),
        .fb_gain  (fb_gain_reg),
        .y        (left_y)
    );

    sfd_chan #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AW           (AW)
    ) u_right (
        .clk      (clk),
        .ctrl     (ctrl),
        .x_in     (right_in),
        .rd_addr  (s1_rd_addr_reg),
        .wr_addr  (s4_wr_addr_reg),
        .dry_gain (dry_gain_reg),
        .wet_gain (wet_gain_reg),
        .fb_gain  (fb_gain_reg),
        .y        (right_y)
    );

    // ------------------------------------------------------------------
    // Output queue. Results leave stage three into a small register queue,
    // which parts the datapath from the output handshake.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] left_q  [sfd_pkg::OUT_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] right_q [sfd_pkg::OUT_DEPTH];
    logic                           mark_q  [sfd_pkg::OUT_DEPTH];
    logic [QPW-1:0]                 q_wp_reg;
    logic [QPW-1:0]                 q_rp_reg;
    logic [CNTW-1:0]                q_cnt_reg;
    logic [CNTW-1:0]                q_cnt_next;

    assign out_valid     = (q_cnt_reg != '0);
    assign out_fire      = out_valid && !out_stall;
    assign left_out      = left_q[q_rp_reg];
    assign right_out     = right_q[q_rp_reg];
    assign block_end_out = mark_q[q_rp_reg];

    always_comb
    begin
        pend_next  = pend_reg + CNTW'(in_fire) - CNTW'(out_fire);
        q_cnt_next = q_cnt_reg + CNTW'(s3_vld_reg) - CNTW'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            q_cnt_reg <= '0;
            q_wp_reg  <= '0;
            q_rp_reg  <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            q_cnt_reg <= q_cnt_next;
            if (s3_vld_reg)
            begin
                q_wp_reg <= q_wp_reg + QPW'(1);
            end
            if (out_fire)
            begin
                q_rp_reg <= q_rp_reg + QPW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_vld_reg)
        begin
            left_q[q_wp_reg]  <= left_y;
            right_q[q_wp_reg] <= right_y;
            mark_q[q_wp_reg]  <= s3_mark_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_port_shared: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.rd_en && ctrl.wr_en))
        else $error("delay store read and write requested in the same cycle");

    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        s2_fwd_reg |-> s4_wen_reg)
        else $error("forwarded sample has no write in flight");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= OUT_FULL)
        else $error("more frames in flight than the output queue holds");

    a_queue_in_pend: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= pend_reg)
        else $error("output queue holds more beats than frames pending");

    a_wr_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !bypass_reg && (wr_pos_reg != LAST_POS))
            |=> (wr_pos_reg == $past(wr_pos_reg) + AW'(1)))
        else $error("write position did not advance after a processed frame");

endmodule

// ===== verif/stereo_feedback_delay_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stereo feedback delay core, with a bit-true echo predictor.
module stereo_feedback_delay_core_tb;

    localparam int LINE_DEPTH    = sfd_pkg::DEF_BUFFER_DEPTH;
    localparam int SW            = sfd_pkg::DEF_SAMPLE_WIDTH;
    localparam int RANDOM_FRAMES = 540;

    // Register indexes past the last defined register are decoded as nothing.
    localparam int FIRST_SPARE_REG = int'(sfd_pkg::CFG_WET_GAIN) + 1;
    localparam int LAST_SPARE_REG  = (1 << sfd_pkg::CFG_IDX_W) - 1;

    localparam longint SAMPLE_TOP    = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAMPLE_BOTTOM = -SAMPLE_TOP - 1;

    localparam logic [SW-1:0] PEAK_POS  = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0] PEAK_NEG  = {1'b1, {(SW - 1){1'b0}}};
    localparam logic [SW-1:0] MINUS_ONE = '1;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic          block_end;
    } stereo_frame_t;

    // Clock, reset and every input of the block start from known values.
    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_stall;
    logic signed [SW-1:0]           left_in      = '0;
    logic signed [SW-1:0]           right_in     = '0;
    logic                           block_end_in = 1'b0;
    logic                           out_valid;
    logic                           out_stall    = 1'b0;
    logic signed [SW-1:0]           left_out;
    logic signed [SW-1:0]           right_out;
    logic                           block_end_out;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

    // Frames waiting to be offered, and mixed frames waiting to come out.
    stereo_frame_t frames_to_send [$];
    stereo_frame_t awaited_mix [$];

    // Idling controls set by the sequencing block, and the driver's flag for a taken beat.
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_sender    = 1'b0;
    bit          beat_taken     = 1'b0;

    // Run statistics.
    int unsigned fault_count     = 0;
    int unsigned frames_in       = 0;
    int unsigned results_out     = 0;
    int unsigned bypassed_frames = 0;
    int unsigned reg_writes      = 0;

    // Predictor state: both delay lines share one array, the left line first and the
    // right line after it. Every entry starts at zero, as the hardware reads unwritten entries.
    bit signed [SW-1:0]            echo_line [0:2*LINE_DEPTH-1];
    int unsigned                   line_head    = 0;
    bit                            bypass_set   = 1'b0;
    logic [sfd_pkg::DELAY_W-1:0]   delay_set    = sfd_pkg::DELAY_RESET;
    logic [sfd_pkg::GAIN_IN_W-1:0] feedback_set = sfd_pkg::GAIN_RESET;
    logic [sfd_pkg::GAIN_IN_W-1:0] wet_set      = sfd_pkg::GAIN_RESET;

    stereo_feedback_delay_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_in       (left_in),
        .right_in      (right_in),
        .block_end_in  (block_end_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .block_end_out (block_end_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // A hang anywhere in the run ends here.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [SW-1:0] clip_sample(input longint v);
        if (v > SAMPLE_TOP)
            return SW'(SAMPLE_TOP);
        if (v < SAMPLE_BOTTOM)
            return SW'(SAMPLE_BOTTOM);
        return SW'(v);
    endfunction

    // Works out the mixed frame for one accepted input frame and updates the delay lines.
    // Shifts on signed longint values round towards minus infinity, as the hardware does.
    function automatic stereo_frame_t echo_mix(input stereo_frame_t x);
        stereo_frame_t y;
        int unsigned   span;
        int unsigned   tap;
        int            ch;
        longint        fb;
        longint        wet;
        longint        xs;
        longint        ds;
        logic [SW-1:0] mixed;
        y = x;
        if (bypass_set)
        begin
            bypassed_frames++;
            return y;
        end
        // A zero delay behaves as one sample, and anything beyond the store as the
        // whole store, in which case the tap lands on the entry about to be overwritten.
        span = delay_set;
        if (span == 0)
            span = 1;
        if (span > LINE_DEPTH)
            span = LINE_DEPTH;
        tap = line_head + LINE_DEPTH - span;
        if (tap >= LINE_DEPTH)
            tap -= LINE_DEPTH;
        fb = feedback_set;
        if (fb > longint'(sfd_pkg::Q15_ONE))
            fb = longint'(sfd_pkg::Q15_ONE);
        wet = wet_set;
        if (wet > longint'(sfd_pkg::Q15_ONE))
            wet = longint'(sfd_pkg::Q15_ONE);
        for (ch = 0; ch < 2; ch++)
        begin
            xs = (ch == 0) ? $signed(x.left) : $signed(x.right);
            ds = echo_line[ch * LINE_DEPTH + tap];
            mixed = clip_sample(((longint'(sfd_pkg::Q15_ONE) - wet) * xs + wet * ds)
                                >>> sfd_pkg::Q15_SHIFT);
            echo_line[ch * LINE_DEPTH + line_head] =
                clip_sample(xs + ((fb * ds) >>> sfd_pkg::Q15_SHIFT));
            if (ch == 0)
                y.left = mixed;
            else
                y.right = mixed;
        end
        line_head = (line_head + 1) % LINE_DEPTH;
        return y;
    endfunction

    // Mirrors a register write into the predictor; unknown indexes change nothing.
    function automatic void apply_reg(input logic [sfd_pkg::CFG_IDX_W-1:0] index,
                                      input logic [sfd_pkg::CFG_DATA_W-1:0] data);
        case (index)
            sfd_pkg::CFG_BYPASS:   bypass_set   = data[0];
            sfd_pkg::CFG_DELAY:    delay_set    = data[sfd_pkg::DELAY_W-1:0];
            sfd_pkg::CFG_FB_GAIN:  feedback_set = data[sfd_pkg::GAIN_IN_W-1:0];
            sfd_pkg::CFG_WET_GAIN: wet_set      = data[sfd_pkg::GAIN_IN_W-1:0];
            default:               ;
        endcase
    endfunction

    // Full-scale values turn up often enough to push the sums into saturation.
    function automatic logic [SW-1:0] draw_sample();
        case ($urandom_range(11))
            0:       return PEAK_POS;
            1:       return PEAK_NEG;
            2:       return '0;
            3:       return MINUS_ONE;
            default: return SW'($urandom);
        endcase
    endfunction

    // Gains over the whole data width: the top bits are dropped and values above unity
    // are held at unity.
    function automatic logic [sfd_pkg::CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(7))
            0:       return '0;
            1:       return sfd_pkg::CFG_DATA_W'(sfd_pkg::Q15_ONE);
            2:       return sfd_pkg::CFG_DATA_W'($urandom);
            default: return sfd_pkg::CFG_DATA_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic void queue_frame(input logic [SW-1:0] l, input logic [SW-1:0] r,
                                        input logic e);
        stereo_frame_t f;
        f.left      = l;
        f.right     = r;
        f.block_end = e;
        frames_to_send.push_back(f);
    endfunction

    // Returns once every queued frame has gone in and every mixed frame has come out.
    // It always looks at a rising edge, where the driver's last changes have settled.
    task automatic settle();
        do
            @(posedge clk);
        while (frames_to_send.size() != 0 || in_valid || awaited_mix.size() != 0);
    endtask

    // One beat on the register port, held until the block takes it.
    task automatic write_reg(input logic [sfd_pkg::CFG_IDX_W-1:0] index,
                             input logic [sfd_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(index, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Input driver. A new beat is only put up once the previous one has been taken, so
    // a stalled payload stays put, and the decision to idle never looks at the stall.
    always @(negedge clk)
    begin : feed_frames
        stereo_frame_t pick;
        if (rst_n && (!in_valid || beat_taken))
        begin
            if (!hold_sender && frames_to_send.size() != 0 &&
                $urandom_range(99) >= send_gap_pct)
            begin
                pick = frames_to_send.pop_front();
                in_valid     <= 1'b1;
                left_in      <= pick.left;
                right_in     <= pick.right;
                block_end_in <= pick.block_end;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    // The receiver holds off at random, at the rate the current phase asks for.
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor. Every accepted input beat is run through the predictor at once; every
    // accepted output beat is compared with the oldest prediction still waiting.
    always @(posedge clk)
    begin : watch_ports
        stereo_frame_t seen;
        stereo_frame_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen.left      = left_in;
                seen.right     = right_in;
                seen.block_end = block_end_in;
                awaited_mix.push_back(echo_mix(seen));
                beat_taken = 1'b1;
                frames_in++;
            end
            if (out_valid && !out_stall)
            begin
                results_out++;
                if (awaited_mix.size() == 0)
                begin
                    $error("Output beat with no frame outstanding: left_out %0d, right_out %0d.",
                           left_out, right_out);
                    fault_count++;
                end
                else
                begin
                    want = awaited_mix.pop_front();
                    if (want.left !== left_out)
                    begin
                        $error("left_out: expected %0d, got %0d.", $signed(want.left), left_out);
                        fault_count++;
                    end
                    if (want.right !== right_out)
                    begin
                        $error("right_out: expected %0d, got %0d.", $signed(want.right),
                               right_out);
                        fault_count++;
                    end
                    if (want.block_end !== block_end_out)
                    begin
                        $error("block_end_out: expected %0b, got %0b.", want.block_end,
                               block_end_out);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Sequencing: directed frames, three phases of random frames, then short runs at a
    // feeding-back echo, at full depth, beyond the depth, just short of it and at a short delay.
    initial
    begin : run_test
        int unsigned phase;
        int unsigned phase_frames;
        int unsigned burst;
        int unsigned span;
        bit          first;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The sender is often quiet while the receiver holds off most of the time.
        send_gap_pct   = 31;
        recv_stall_pct = 85;

        // Reset settings: a long delay over an empty store, so only the dry half of the
        // input reaches the output.
        queue_frame(PEAK_POS, PEAK_NEG, 1'b1);
        queue_frame(PEAK_NEG, PEAK_POS, 1'b0);
        settle();

        // A zero delay behaves as one sample. All-ones feedback keeps only its low 16
        // bits, which lie above unity and are held there, so repeated full-scale input
        // drives the stored sum into saturation. With no wet gain the output is dry.
        write_reg(sfd_pkg::CFG_DELAY, '0);
        write_reg(sfd_pkg::CFG_FB_GAIN, '1);
        write_reg(sfd_pkg::CFG_WET_GAIN, '0);
        queue_frame(PEAK_POS, PEAK_NEG, 1'b0);
        queue_frame(PEAK_POS, PEAK_NEG, 1'b1);
        queue_frame(PEAK_NEG, PEAK_POS, 1'b0);
        queue_frame(MINUS_ONE, SW'(1), 1'b1);
        settle();

        // A wet gain above unity is held at unity: the output is the delayed sample alone.
        write_reg(sfd_pkg::CFG_WET_GAIN, sfd_pkg::CFG_DATA_W'(18'h1FFFF));
        queue_frame('0, '0, 1'b0);
        queue_frame(SW'(1), MINUS_ONE, 1'b1);
        queue_frame(SW'(16'h5555), SW'(16'hAAAA), 1'b0);
        settle();

        // Bypass copies the frame and must leave the lines and the write position alone.
        write_reg(sfd_pkg::CFG_BYPASS, sfd_pkg::CFG_DATA_W'(1));
        queue_frame(PEAK_POS, PEAK_NEG, 1'b1);
        queue_frame(MINUS_ONE, '0, 1'b0);
        settle();

        // A write to an index with no register behind it is dropped. A delay beyond the
        // store acts as the whole store and reads the entry just before it is replaced.
        write_reg(sfd_pkg::CFG_IDX_W'(LAST_SPARE_REG), '1);
        write_reg(sfd_pkg::CFG_BYPASS, '0);
        write_reg(sfd_pkg::CFG_DELAY, '1);
        queue_frame(PEAK_NEG, PEAK_NEG, 1'b1);
        queue_frame(PEAK_POS, PEAK_POS, 1'b0);
        settle();

        // Exactly the store depth, no feedback, reset wet gain.
        write_reg(sfd_pkg::CFG_DELAY, sfd_pkg::CFG_DATA_W'(LINE_DEPTH));
        write_reg(sfd_pkg::CFG_FB_GAIN, '0);
        write_reg(sfd_pkg::CFG_WET_GAIN, sfd_pkg::CFG_DATA_W'(sfd_pkg::GAIN_RESET));
        queue_frame(SW'(12345), SW'(-12345), 1'b0);
        queue_frame(MINUS_ONE, PEAK_POS, 1'b1);
        settle();

        // Both gains at exactly unity over a two-sample delay.
        write_reg(sfd_pkg::CFG_DELAY, sfd_pkg::CFG_DATA_W'(2));
        write_reg(sfd_pkg::CFG_FB_GAIN, sfd_pkg::CFG_DATA_W'(sfd_pkg::Q15_ONE));
        write_reg(sfd_pkg::CFG_WET_GAIN, sfd_pkg::CFG_DATA_W'(sfd_pkg::Q15_ONE));
        queue_frame(PEAK_POS, PEAK_NEG, 1'b0);
        queue_frame(PEAK_NEG, PEAK_POS, 1'b1);
        queue_frame(PEAK_POS, PEAK_NEG, 1'b0);
        queue_frame('0, MINUS_ONE, 1'b1);

        // Random bursts under fresh settings. Delays are mostly short so that the echo
        // and its feedback build up within a burst; now and then one covers the whole
        // register range. Once per phase the sender stops half-way through a burst and
        // waits for every outstanding beat to come back before it carries on.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct   = 31;
                    recv_stall_pct = 85;
                end
                1:
                begin
                    send_gap_pct   = 85;
                    recv_stall_pct = 31;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_frames = 0;
            first        = 1'b1;
            while (phase_frames < RANDOM_FRAMES / 3)
            begin
                settle();
                write_reg(sfd_pkg::CFG_BYPASS,
                          sfd_pkg::CFG_DATA_W'($urandom_range(6) == 0));
                case ($urandom_range(9))
                    0:       span = 0;
                    1:       span = $urandom_range(1, (1 << sfd_pkg::DELAY_W) - 1);
                    2:       span = LINE_DEPTH;
                    3:       span = $urandom_range(LINE_DEPTH - 4, LINE_DEPTH + 4);
                    default: span = $urandom_range(1, 48);
                endcase
                write_reg(sfd_pkg::CFG_DELAY, sfd_pkg::CFG_DATA_W'(span));
                write_reg(sfd_pkg::CFG_FB_GAIN, pick_gain());
                write_reg(sfd_pkg::CFG_WET_GAIN, pick_gain());
                if ($urandom_range(7) == 0)
                    write_reg(sfd_pkg::CFG_IDX_W'($urandom_range(FIRST_SPARE_REG,
                                                                 LAST_SPARE_REG)),
                              sfd_pkg::CFG_DATA_W'($urandom));
                burst = $urandom_range(12, 40);
                repeat (burst)
                    queue_frame(draw_sample(), draw_sample(), $urandom_range(7) == 0);
                phase_frames += burst;
                if (first)
                begin
                    while (frames_to_send.size() > burst / 2)
                        @(posedge clk);
                    hold_sender = 1'b1;
                    do
                        @(posedge clk);
                    while (in_valid || awaited_mix.size() != 0);
                    hold_sender = 1'b0;
                    first       = 1'b0;
                end
            end
        end

        // A short feeding-back echo, then reads at full depth, beyond it and one short
        // of it, and finally a short delay again.
        settle();
        write_reg(sfd_pkg::CFG_BYPASS, '0);
        write_reg(sfd_pkg::CFG_DELAY, sfd_pkg::CFG_DATA_W'(19));
        write_reg(sfd_pkg::CFG_FB_GAIN, sfd_pkg::CFG_DATA_W'(24000));
        write_reg(sfd_pkg::CFG_WET_GAIN, sfd_pkg::CFG_DATA_W'(9000));
        repeat (64)
            queue_frame(draw_sample(), draw_sample(), $urandom_range(15) == 0);
        settle();
        write_reg(sfd_pkg::CFG_DELAY, sfd_pkg::CFG_DATA_W'(LINE_DEPTH));
        write_reg(sfd_pkg::CFG_FB_GAIN, sfd_pkg::CFG_DATA_W'(sfd_pkg::Q15_ONE));
        write_reg(sfd_pkg::CFG_WET_GAIN, sfd_pkg::CFG_DATA_W'(sfd_pkg::Q15_ONE));
        repeat (32)
            queue_frame(draw_sample(), draw_sample(), $urandom_range(7) == 0);
        settle();
        write_reg(sfd_pkg::CFG_DELAY, '1);
        repeat (16)
            queue_frame(draw_sample(), draw_sample(), $urandom_range(1));
        settle();
        write_reg(sfd_pkg::CFG_DELAY, sfd_pkg::CFG_DATA_W'(LINE_DEPTH - 1));
        write_reg(sfd_pkg::CFG_WET_GAIN, sfd_pkg::CFG_DATA_W'(sfd_pkg::GAIN_RESET));
        repeat (16)
            queue_frame(draw_sample(), draw_sample(), $urandom_range(1));
        settle();
        write_reg(sfd_pkg::CFG_DELAY, sfd_pkg::CFG_DATA_W'(3));
        repeat (16)
            queue_frame(draw_sample(), draw_sample(), $urandom_range(1));

        // Drain, then let the clock run on so that any stray beat shows.
        settle();
        repeat (8) @(posedge clk);
        if (awaited_mix.size() != 0)
        begin
            $error("%0d mixed frames never came out.", awaited_mix.size());
            fault_count++;
        end
        $display("Covered %0d frames and %0d output beats, %0d in bypass, %0d register writes.",
                 frames_in, results_out, bypassed_frames, reg_writes);
        $display("Delays ran from zero to past the store; gaps at 31/85, 85/31, 0/0 per cent.");
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sfd_pkg.sv
rtl/sfd_chan.sv
rtl/stereo_feedback_delay_core.sv
verif/stereo_feedback_delay_core_tb.sv
